// File: sv/cmkc_pkg.sv
// Types and constants shared by the motor kick controller.
package cmkc_pkg;

  localparam int unsigned IdW    = 11;
  localparam int unsigned LenW   = 4;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PulseW = 12;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  localparam logic [PulseW-1:0] NeutralPulse = PulseW'(1500);
  localparam logic [CountW-1:0] CountMax     = {CountW{1'b1}};

  localparam logic [ByteW-1:0] CmdStop   = 8'h00;
  localparam logic [ByteW-1:0] CmdSpeed1 = 8'h01;
  localparam logic [ByteW-1:0] CmdSpeed2 = 8'h02;
  localparam logic [ByteW-1:0] CmdSpeed3 = 8'h03;
  localparam logic [ByteW-1:0] CmdSpeed4 = 8'h04;
  localparam logic [ByteW-1:0] CmdEmpty  = 8'hFF;

  localparam logic ActTick = 1'b0;
  localparam logic ActMsg  = 1'b1;

  typedef enum logic [1:0] {
    ModeStopped = 2'd0,
    ModeKicking = 2'd1,
    ModeRunning = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegTargetId   = 3'd0,
    RegSpeedOne   = 3'd1,
    RegSpeedTwo   = 3'd2,
    RegSpeedThree = 3'd3,
    RegSpeedFour  = 3'd4,
    RegKickPulse  = 3'd5,
    RegKickMs     = 3'd6,
    RegTimeoutMs  = 3'd7
  } cfg_reg_e;

endpackage

// File: sv/can_command_motor_kick_controller.sv
// Motor kick controller: bus command and tick stream in, servo drive stream out.
//
// Input channel s_axis: one item per tick (tuser = 0) or received bus message
// (tuser = 1). tdata carries msg_id, msg_len and cmd_byte. Each item yields
// exactly one result item on m_axis: the servo pulse width now driven and the
// motor mode (0 stopped, 1 kicking, 2 running).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at a clock
// edge; write only while no item is in flight.
// An item's result is registered in the output register, or in the skid
// register while m_axis stalls. Throughput: one item per cycle while tready is
// high; the state update is one compare and select pass between state registers.
// Stalls: an output register plus one skid register hold results, so s_axis
// takes an item whenever the skid register is empty; with m_axis stalled, two
// results are held and s_axis then deasserts tready until one is taken.
// Reset: rst_ni clears the valid flags of both result registers, puts the motor
// in the stopped mode at the neutral pulse of 1500 us, clears both counters and
// loads the default register values.
module can_command_motor_kick_controller
  import cmkc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // msg_id, msg_len, cmd_byte, zero pad
  input  logic                s_axis_tuser,  // action
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata   // drive_pulse_us, motor_mode, zero pad
);

  logic [IdW-1:0]    target_id_q;
  logic [PulseW-1:0] speed1_q, speed2_q, speed3_q, speed4_q, kick_pulse_q;
  logic [MsW-1:0]    kick_ms_q, timeout_q;

  mode_e             mode_q, mode_d;
  logic [PulseW-1:0] run_q, run_d, drive_q, drive_d;
  logic [CountW-1:0] kick_cnt_q, kick_cnt_d, sil_cnt_q, sil_cnt_d;

  logic                out_valid_q, skid_valid_q;
  logic [OutDataW-1:0] out_data_q, skid_data_q;

  logic [IdW-1:0]   msg_id;
  logic [LenW-1:0]  msg_len;
  logic [ByteW-1:0] cmd_byte, cmd;
  logic             in_hs, out_hs;
  logic [OutDataW-1:0] result;

  assign msg_id   = s_axis_tdata[IdW-1:0];
  assign msg_len  = s_axis_tdata[IdW+LenW-1:IdW];
  assign cmd_byte = s_axis_tdata[IdW+LenW+ByteW-1:IdW+LenW];
  assign cmd      = (msg_len != '0) ? cmd_byte : CmdEmpty;

  assign s_axis_tready = !skid_valid_q;
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign out_hs        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    mode_d     = mode_q;
    run_d      = run_q;
    drive_d    = drive_q;
    kick_cnt_d = kick_cnt_q;
    sil_cnt_d  = sil_cnt_q;
    if (s_axis_tuser == ActTick) begin
      kick_cnt_d = (kick_cnt_q == CountMax) ? CountMax : kick_cnt_q + 1'b1;
      sil_cnt_d  = (sil_cnt_q == CountMax) ? CountMax : sil_cnt_q + 1'b1;
    end else if (msg_id == target_id_q) begin
      sil_cnt_d = '0;
      case (cmd)
        CmdSpeed1, CmdSpeed2, CmdSpeed3, CmdSpeed4: begin
          case (cmd)
            CmdSpeed1: run_d = speed1_q;
            CmdSpeed2: run_d = speed2_q;
            CmdSpeed3: run_d = speed3_q;
            default:   run_d = speed4_q;
          endcase
          if (mode_q == ModeStopped) begin
            mode_d     = ModeKicking;
            kick_cnt_d = '0;
            drive_d    = kick_pulse_q;
          end
        end
        CmdStop: begin
          mode_d  = ModeStopped;
          drive_d = NeutralPulse;
        end
        default: ;
      endcase
    end
    if (mode_d == ModeKicking && kick_cnt_d > CountW'(kick_ms_q)) begin
      mode_d  = ModeRunning;
      drive_d = run_d;
    end
    if (sil_cnt_d > CountW'(timeout_q) && mode_d != ModeStopped) begin
      mode_d  = ModeStopped;
      drive_d = NeutralPulse;
    end
  end

  assign result = {{(OutDataW-PulseW-2){1'b0}}, mode_d, drive_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_id_q  <= IdW'(769);
      speed1_q     <= PulseW'(1750);
      speed2_q     <= PulseW'(1770);
      speed3_q     <= PulseW'(1800);
      speed4_q     <= PulseW'(1823);
      kick_pulse_q <= PulseW'(2000);
      kick_ms_q    <= MsW'(75);
      timeout_q    <= MsW'(200);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegTargetId:   target_id_q  <= cfg_data_i[IdW-1:0];
        RegSpeedOne:   speed1_q     <= cfg_data_i[PulseW-1:0];
        RegSpeedTwo:   speed2_q     <= cfg_data_i[PulseW-1:0];
        RegSpeedThree: speed3_q     <= cfg_data_i[PulseW-1:0];
        RegSpeedFour:  speed4_q     <= cfg_data_i[PulseW-1:0];
        RegKickPulse:  kick_pulse_q <= cfg_data_i[PulseW-1:0];
        RegKickMs:     kick_ms_q    <= cfg_data_i[MsW-1:0];
        RegTimeoutMs:  timeout_q    <= cfg_data_i[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeStopped;
      run_q      <= NeutralPulse;
      drive_q    <= NeutralPulse;
      kick_cnt_q <= '0;
      sil_cnt_q  <= '0;
    end else if (in_hs) begin
      mode_q     <= mode_d;
      run_q      <= run_d;
      drive_q    <= drive_d;
      kick_cnt_q <= kick_cnt_d;
      sil_cnt_q  <= sil_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_hs) begin
        out_valid_q  <= skid_valid_q || in_hs;
        skid_valid_q <= 1'b0;
      end else if (in_hs) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_hs) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
      if (skid_valid_q && in_hs) begin
        skid_data_q <= result;
      end
    end else if (in_hs) begin
      skid_data_q <= result;
    end
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while output register is empty");

  a_stopped_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == ModeStopped |-> drive_q == NeutralPulse)
    else $error("stopped mode drives a pulse other than neutral");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && s_axis_tuser == ActTick) |=> sil_cnt_q != '0)
    else $error("silence count did not advance on a tick");

  a_hs_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> out_valid_q)
    else $error("accepted item left no result");
`endif

endmodule

// File: verif/can_command_motor_kick_controller_tb.sv
// Testbench for the motor kick controller: directed and random ticks and bus commands.
`timescale 1ns / 100ps

module can_command_motor_kick_controller_tb
  import cmkc_pkg::*;
();

  typedef struct packed {
    logic [PulseW-1:0] pulse;
    mode_e             mode;
  } drive_t;

  typedef struct {
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] value;
  } cfg_write_t;

  class drive_scoreboard;
    logic [IdW-1:0]    target_id;
    logic [PulseW-1:0] speed_pulse [4];
    logic [PulseW-1:0] kick_pulse;
    logic [MsW-1:0]    kick_ms;
    logic [MsW-1:0]    timeout_ms;
    mode_e             mode;
    logic [PulseW-1:0] run_pulse;
    logic [PulseW-1:0] drive_pulse;
    logic [CountW-1:0] kick_cnt;
    logic [CountW-1:0] silence_cnt;
    drive_t            drive_q[$];
    int unsigned       errors;
    int unsigned       items;
    int unsigned       results;

    function new();
      target_id      = IdW'(769);
      speed_pulse[0] = PulseW'(1750);
      speed_pulse[1] = PulseW'(1770);
      speed_pulse[2] = PulseW'(1800);
      speed_pulse[3] = PulseW'(1823);
      kick_pulse     = PulseW'(2000);
      kick_ms        = MsW'(75);
      timeout_ms     = MsW'(200);
      mode           = ModeStopped;
      run_pulse      = NeutralPulse;
      drive_pulse    = NeutralPulse;
      kick_cnt       = '0;
      silence_cnt    = '0;
      errors         = 0;
      items          = 0;
      results        = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegTargetId:   target_id      = value[IdW-1:0];
        RegSpeedOne:   speed_pulse[0] = value[PulseW-1:0];
        RegSpeedTwo:   speed_pulse[1] = value[PulseW-1:0];
        RegSpeedThree: speed_pulse[2] = value[PulseW-1:0];
        RegSpeedFour:  speed_pulse[3] = value[PulseW-1:0];
        RegKickPulse:  kick_pulse     = value[PulseW-1:0];
        RegKickMs:     kick_ms        = value[MsW-1:0];
        RegTimeoutMs:  timeout_ms     = value[MsW-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic action, logic [IdW-1:0] id, logic [LenW-1:0] len,
                            logic [ByteW-1:0] first_byte);
      logic [ByteW-1:0] cmd;
      drive_t           next;
      items++;
      if (action == ActTick) begin
        if (kick_cnt != CountMax) kick_cnt++;
        if (silence_cnt != CountMax) silence_cnt++;
      end else if (id == target_id) begin
        cmd = (len != '0) ? first_byte : CmdEmpty;
        silence_cnt = '0;
        if (cmd >= CmdSpeed1 && cmd <= CmdSpeed4) begin
          run_pulse = speed_pulse[2'(cmd - CmdSpeed1)];
          if (mode == ModeStopped) begin
            mode        = ModeKicking;
            kick_cnt    = '0;
            drive_pulse = kick_pulse;
          end
        end else if (cmd == CmdStop) begin
          mode        = ModeStopped;
          drive_pulse = NeutralPulse;
        end
      end
      if (mode == ModeKicking && kick_cnt > CountW'(kick_ms)) begin
        mode        = ModeRunning;
        drive_pulse = run_pulse;
      end
      if (silence_cnt > CountW'(timeout_ms) && mode != ModeStopped) begin
        mode        = ModeStopped;
        drive_pulse = NeutralPulse;
      end
      next.pulse = drive_pulse;
      next.mode  = mode;
      drive_q.push_back(next);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      drive_t            want;
      logic [PulseW-1:0] got_pulse;
      logic [1:0]        got_mode;
      got_pulse = data[PulseW-1:0];
      got_mode  = data[PulseW +: 2];
      results++;
      if (drive_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: pulse %0d mode %0d",
                 $time, got_pulse, got_mode);
        return;
      end
      want = drive_q.pop_front();
      if (got_pulse !== want.pulse) begin
        errors++;
        $display("%0t: drive pulse mismatch: expected %0d actual %0d",
                 $time, want.pulse, got_pulse);
      end
      if (got_mode !== want.mode) begin
        errors++;
        $display("%0t: motor mode mismatch: expected %0d actual %0d",
                 $time, want.mode, got_mode);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // msg_id, msg_len, cmd_byte, zero pad
  logic                s_axis_tuser  = 1'b0;  // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;  // drive_pulse_us, motor_mode, zero pad

  drive_scoreboard sb;
  cfg_write_t      cfg_q[$];
  bit              calm = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     cfg_sets = 0;

  can_command_motor_kick_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left    <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check results before noting inputs so a same-edge input never matches an output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_item(s_axis_tuser, s_axis_tdata[IdW-1:0], s_axis_tdata[IdW +: LenW],
                     s_axis_tdata[IdW+LenW +: ByteW]);
      end
    end
  end

  task automatic send_item(logic action, logic [IdW-1:0] id, logic [LenW-1:0] len,
                           logic [ByteW-1:0] cmd);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {1'b0, cmd, len, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_tick();
    send_item(ActTick, IdW'($urandom()), LenW'($urandom()), ByteW'($urandom()));
  endtask

  task automatic send_msg(logic [IdW-1:0] id, logic [LenW-1:0] len, logic [ByteW-1:0] cmd);
    send_item(ActMsg, id, len, cmd);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.drive_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_cfg();
    cfg_write_t wr;
    while (cfg_q.size() != 0) begin
      wr = cfg_q.pop_front();
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= wr.idx;
      cfg_data_i <= wr.value;
      sb.write_reg(wr.idx, wr.value);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  task automatic queue_cfg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    cfg_write_t wr;
    wr.idx   = idx;
    wr.value = value;
    cfg_q.push_back(wr);
  endtask

  task automatic random_phase(int unsigned phase, int unsigned count, int unsigned calm_from);
    logic [ByteW-1:0] speed_cmds [4];
    logic [IdW-1:0]   id;
    int unsigned      pick;
    int unsigned      k;
    speed_cmds = '{CmdSpeed1, CmdSpeed2, CmdSpeed3, CmdSpeed4};
    for (k = 0; k < 8; k++) begin
      if (phase == 0) queue_cfg(cfg_reg_e'(k), '0);
      else if (phase == 1) queue_cfg(cfg_reg_e'(k), '1);
      else if (cfg_reg_e'(k) == RegKickMs) begin
        queue_cfg(cfg_reg_e'(k), CfgDataW'($urandom_range(0, 15)));
      end else if (cfg_reg_e'(k) == RegTimeoutMs) begin
        queue_cfg(cfg_reg_e'(k), CfgDataW'($urandom_range(0, 40)));
      end else queue_cfg(cfg_reg_e'(k), CfgDataW'($urandom()));
    end
    apply_cfg();
    for (k = 0; k < count; k++) begin
      if (phase * count + k >= calm_from) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_tick();
      end else if (pick < 85) begin
        if ($urandom_range(0, 5) == 0) begin
          send_msg(sb.target_id, LenW'($urandom_range(1, 8)), CmdStop);
        end else begin
          send_msg(sb.target_id, LenW'($urandom_range(1, 8)),
                   speed_cmds[2'($urandom_range(0, 3))]);
        end
      end else begin
        id = $urandom_range(0, 1) ? sb.target_id : IdW'($urandom());
        send_msg(id, LenW'($urandom()), ByteW'($urandom()));
      end
    end
    drain();
  endtask

  initial begin
    #(8_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned n;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default registers: foreign ids, empty and long messages, unknown commands.
    send_tick();
    send_msg(IdW'(768), 4'd1, CmdSpeed1);
    send_msg(IdW'(769), 4'd0, CmdSpeed1);
    send_msg(IdW'(769), 4'd15, 8'h05);
    send_msg(IdW'(769), 4'd15, CmdSpeed1);
    send_msg(IdW'(769), 4'd8, CmdSpeed3);
    send_tick();
    send_msg(IdW'(2047), 4'd8, CmdStop);
    send_msg(IdW'(769), 4'd1, CmdStop);
    send_msg(IdW'(769), 4'd1, CmdSpeed4);
    send_msg(IdW'(769), 4'd2, CmdEmpty);
    send_msg(IdW'(769), 4'd1, CmdStop);
    drain();

    // Short kick and timeout: run, change speed while running, then time out.
    queue_cfg(RegTargetId, '0);
    queue_cfg(RegKickMs, '0);
    queue_cfg(RegTimeoutMs, 16'd2);
    queue_cfg(RegSpeedTwo, 16'hFFFF);
    queue_cfg(RegKickPulse, '0);
    apply_cfg();
    send_msg('0, 4'd1, CmdSpeed2);
    send_tick();
    send_msg('0, 4'd1, CmdSpeed1);
    repeat (3) send_tick();
    send_msg('0, 4'd0, CmdStop);
    send_msg('0, 4'd1, CmdStop);
    send_msg('0, 4'd4, 8'h80);
    drain();

    for (n = 0; n < 6; n++) random_phase(n, 108, 550);

    drain();
    $display("Run covered %0d items and %0d results over %0d register settings,",
             sb.items, sb.results, cfg_sets);
    $display("including kick, run, speed change, stop, silence timeout and foreign ids.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/cmkc_pkg.sv
sv/can_command_motor_kick_controller.sv
verif/can_command_motor_kick_controller_tb.sv
